FILE: rtl/atep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atep_pkg
// Shared types and character constants for the adjacency text edge parser.
// ----------------------------------------------------------------------------
package atep_pkg;

   localparam int unsigned WORD_W = 64;

   localparam logic [1:0] MODE_BLANK  = 2'd0;
   localparam logic [1:0] MODE_SIGN   = 2'd1;
   localparam logic [1:0] MODE_DIGITS = 2'd2;

   localparam logic [7:0] CHAR_LF      = 8'd10;
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_PERCENT = 8'd37;
   localparam logic [7:0] CHAR_PLUS    = 8'd43;
   localparam logic [7:0] CHAR_MINUS   = 8'd45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;

   localparam logic [WORD_W-1:0] CUT_VALUE = 64'd1844674407370955161;
   localparam logic [3:0]        CUT_DIGIT = 4'd5;

   typedef struct packed {
      logic [WORD_W-1:0] line_number;
      logic [WORD_W-1:0] accumulator;
      logic [1:0]        token_mode;
      logic              negative_sign;
      logic              overflowed;
      logic              at_line_start;
      logic              in_comment;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      line_number:   '0,
      accumulator:   '0,
      token_mode:    MODE_BLANK,
      negative_sign: 1'b0,
      overflowed:    1'b0,
      at_line_start: 1'b1,
      in_comment:    1'b0
   };

endpackage
`default_nettype wire

FILE: rtl/adjacency_text_edge_parser_core.sv
// Path: an accepted request passes the input register, then the result
//    register, before its edge, if any, shows on rsp_valid.
// Throughput: one text byte per cycle; a held edge stalls the input stage
//    until rsp_ready.
// Reset: synchronous; clears the line counter, token state and both valid
//    flags.
`default_nettype none
// ----------------------------------------------------------------------------
// adjacency_text_edge_parser_core
// Streams adjacency-list text bytes and emits (source, target) edges.
// ----------------------------------------------------------------------------
module adjacency_text_edge_parser_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_text,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_edge_source,
   output logic [63:0]      rsp_edge_target
);
   import atep_pkg::*;

   logic            in_vld_ff;
   logic            in_vld_in;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            rsp_vld_ff;
   logic            rsp_vld_in;
   logic [63:0]     src_ff;
   logic [63:0]     tgt_ff;
   logic            adv;
   logic            emit;
   logic [63:0]     src;
   logic [63:0]     tgt;

   atep_step u_step (
      .cur_state   (state_ff),
      .text_byte   (in_byte_ff),
      .end_of_text (in_last_ff),
      .nxt_state   (state_in),
      .edge_emit   (emit),
      .edge_source (src),
      .edge_target (tgt)
   );

   assign adv        = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready  = !in_vld_ff || adv;
   assign in_vld_in  = (req_valid && req_ready) || (in_vld_ff && !adv);
   assign rsp_vld_in = adv ? emit : (rsp_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= STATE_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (adv) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_end_of_text;
      end
      if (adv && emit) begin
         src_ff <= src;
         tgt_ff <= tgt;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_edge_source = src_ff;
   assign rsp_edge_target = tgt_ff;

`ifndef SYNTHESIS
   a_edge_order: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (src_ff <= tgt_ff))
      else $error("edge target below source");

   a_line_hold: assert property (@(posedge clock) disable iff (reset)
      (adv && (in_byte_ff != CHAR_LF) && !in_last_ff) |=>
         (state_ff.line_number == $past(state_ff.line_number)))
      else $error("line counter moved mid-line");

   a_line_step: assert property (@(posedge clock) disable iff (reset)
      (adv && ((in_byte_ff == CHAR_LF) || in_last_ff)) |=>
         ((state_ff.line_number == $past(state_ff.line_number) + 64'd1) &&
          state_ff.at_line_start && (state_ff.token_mode == MODE_BLANK)))
      else $error("line close did not advance");

   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> req_ready)
      else $error("empty input stage not ready");

   a_no_emit_comment: assert property (@(posedge clock) disable iff (reset)
      (adv && state_ff.in_comment) |-> !emit)
      else $error("edge from comment line");
`endif

endmodule
`default_nettype wire

FILE: rtl/atep_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atep_step
// Next-state and edge logic for one text byte of the adjacency parser.
// ----------------------------------------------------------------------------
module atep_step (
   input  atep_pkg::parse_state_type cur_state,
   input  logic [7:0]                text_byte,
   input  logic                      end_of_text,
   output atep_pkg::parse_state_type nxt_state,
   output logic                      edge_emit,
   output logic [63:0]               edge_source,
   output logic [63:0]               edge_target
);
   import atep_pkg::*;

   parse_state_type mid;
   logic            fin_a;
   logic            fin_b;
   logic            comment;
   logic            digit;
   logic [3:0]      d;
   logic [WORD_W-1:0] fin_acc;
   logic            fin_neg;
   logic            fin_ovf;
   logic [WORD_W-1:0] target;
   logic            nonzero;

   assign digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
   assign d     = digit ? 4'(text_byte - CHAR_ZERO) : 4'd0;

   // byte phase
   always_comb begin
      mid     = cur_state;
      fin_a   = 1'b0;
      comment = cur_state.in_comment;
      if (text_byte == CHAR_LF) begin
         fin_a = !cur_state.in_comment && (cur_state.token_mode != MODE_BLANK);
      end else begin
         if (cur_state.at_line_start) begin
            mid.at_line_start = 1'b0;
            if (text_byte == CHAR_PERCENT) begin
               comment = 1'b1;
            end
         end
         mid.in_comment = comment;
         if (!comment) begin
            case (cur_state.token_mode)
               MODE_DIGITS: begin
                  if (digit) begin
                     if (cur_state.overflowed || (cur_state.accumulator > CUT_VALUE) ||
                         ((cur_state.accumulator == CUT_VALUE) && (d > CUT_DIGIT))) begin
                        mid.overflowed = 1'b1;
                     end else begin
                        mid.accumulator = (cur_state.accumulator << 3) +
                                          (cur_state.accumulator << 1) +
                                          WORD_W'(d);
                     end
                  end else begin
                     fin_a = 1'b1;
                  end
               end
               MODE_SIGN: begin
                  if (digit) begin
                     mid.accumulator = WORD_W'(d);
                     mid.token_mode  = MODE_DIGITS;
                  end else begin
                     fin_a = 1'b1;
                  end
               end
               default: begin
                  if ((text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB)) begin
                     mid.token_mode = MODE_BLANK;
                  end else if (text_byte == CHAR_MINUS) begin
                     mid.negative_sign = 1'b1;
                     mid.token_mode    = MODE_SIGN;
                  end else if (text_byte == CHAR_PLUS) begin
                     mid.token_mode = MODE_SIGN;
                  end else if (digit) begin
                     mid.accumulator = WORD_W'(d);
                     mid.token_mode  = MODE_DIGITS;
                  end else begin
                     fin_a = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // close a pending token at end of text
   assign fin_b = (text_byte != CHAR_LF) && end_of_text && !fin_a &&
                  !mid.in_comment && (mid.token_mode != MODE_BLANK);

   assign fin_acc = fin_a ? cur_state.accumulator   : mid.accumulator;
   assign fin_neg = fin_a ? cur_state.negative_sign : mid.negative_sign;
   assign fin_ovf = fin_a ? cur_state.overflowed    : mid.overflowed;

   // value minus one; -acc - 1 is ~acc
   always_comb begin
      if (fin_ovf) begin
         target  = {{(WORD_W-1){1'b1}}, 1'b0};
         nonzero = 1'b1;
      end else if (fin_neg) begin
         target  = ~fin_acc;
         nonzero = (fin_acc != '0);
      end else begin
         target  = fin_acc - WORD_W'(1);
         nonzero = (fin_acc != '0);
      end
   end

   assign edge_emit   = (fin_a || fin_b) && nonzero && (cur_state.line_number <= target);
   assign edge_source = cur_state.line_number;
   assign edge_target = target;

   // commit phase
   always_comb begin
      nxt_state = mid;
      if (fin_a || fin_b) begin
         nxt_state.accumulator   = '0;
         nxt_state.token_mode    = MODE_BLANK;
         nxt_state.negative_sign = 1'b0;
         nxt_state.overflowed    = 1'b0;
      end
      if ((text_byte == CHAR_LF) || end_of_text) begin
         nxt_state.accumulator   = '0;
         nxt_state.token_mode    = MODE_BLANK;
         nxt_state.negative_sign = 1'b0;
         nxt_state.overflowed    = 1'b0;
         nxt_state.line_number   = cur_state.line_number + WORD_W'(1);
         nxt_state.at_line_start = 1'b1;
         nxt_state.in_comment    = 1'b0;
      end
   end

endmodule
`default_nettype wire

FILE: tb/adjacency_text_edge_parser_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_text_edge_parser_core_test
// Streams adjacency-list text into the parser, one byte per request, and
// checks each (source, target) edge against an in-bench parser. A short
// directed text comes first, then random lines: well-formed neighbor lists
// with random values, blanks, signs and saturating numbers, mixed with
// comment, empty and noise lines. Both sides stall at random in the first
// two of three phases only; the source drains fully between phases.
// ----------------------------------------------------------------------------
module adjacency_text_edge_parser_core_test;
   import atep_pkg::*;

   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_BYTES = 260;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } text_request_type;

   typedef struct packed {
      logic [63:0] source;
      logic [63:0] target;
   } parsed_edge_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = 8'd0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_edge_source;
   logic [63:0] rsp_edge_target;

   text_request_type pending_requests[$];
   parsed_edge_type  expected_edges[$];

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int fail_count = 0;
   int bytes_accepted = 0;
   int edges_checked = 0;
   int idle_cycles = 0;

   // parser state mirrored in the bench
   logic [63:0] line_index = '0;
   logic [63:0] digit_value = '0;
   logic [1:0]  token_state = MODE_BLANK;
   logic        minus_seen = 1'b0;
   logic        saturated = 1'b0;
   logic        line_fresh = 1'b1;
   logic        comment_line = 1'b0;

   adjacency_text_edge_parser_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_edge_source (rsp_edge_source),
      .rsp_edge_target (rsp_edge_target)
   );

   always #4 clock = ~clock;

   function automatic void clear_number();
      digit_value = '0;
      token_state = MODE_BLANK;
      minus_seen = 1'b0;
      saturated = 1'b0;
   endfunction

   function automatic logic close_number();
      logic [63:0] value;
      if (saturated)
         value = '1;
      else if (minus_seen)
         value = 64'd0 - digit_value;
      else
         value = digit_value;
      clear_number();
      if (line_index < value && value != 0) begin
         expected_edges.push_back('{source: line_index, target: value - 64'd1});
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void close_line();
      clear_number();
      line_index = line_index + 64'd1;
      line_fresh = 1'b1;
      comment_line = 1'b0;
   endfunction

   function automatic void parse_text_byte(input logic [7:0] b, input logic last);
      logic       digit;
      logic [3:0] d;
      logic       emitted;
      emitted = 1'b0;
      if (b == CHAR_LF) begin
         if (!comment_line && token_state != MODE_BLANK)
            emitted = close_number();
         close_line();
         return;
      end
      if (line_fresh) begin
         line_fresh = 1'b0;
         if (b == CHAR_PERCENT)
            comment_line = 1'b1;
      end
      if (!comment_line) begin
         digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
         d = digit ? 4'(b - CHAR_ZERO) : 4'd0;
         case (token_state)
            MODE_DIGITS: begin
               if (digit) begin
                  if (saturated || digit_value > CUT_VALUE ||
                      (digit_value == CUT_VALUE && d > CUT_DIGIT))
                     saturated = 1'b1;
                  else
                     digit_value = digit_value * 64'd10 + 64'(d);
               end else begin
                  emitted = close_number();
               end
            end
            MODE_SIGN: begin
               if (digit) begin
                  digit_value = 64'(d);
                  token_state = MODE_DIGITS;
               end else begin
                  emitted = close_number();
               end
            end
            default: begin
               if (b == CHAR_SPACE || b == CHAR_TAB) begin
               end else if (b == CHAR_MINUS) begin
                  minus_seen = 1'b1;
                  token_state = MODE_SIGN;
               end else if (b == CHAR_PLUS) begin
                  token_state = MODE_SIGN;
               end else if (digit) begin
                  digit_value = 64'(d);
                  token_state = MODE_DIGITS;
               end else begin
                  emitted = close_number();
               end
            end
         endcase
      end
      if (last) begin
         if (!comment_line && token_state != MODE_BLANK && !emitted)
            emitted = close_number();
         if (!line_fresh)
            close_line();
         else
            clear_number();
      end
   endfunction

   task automatic add_byte(input logic [7:0] value, input logic last);
      pending_requests.push_back('{text_byte: value, end_of_text: last});
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i], 1'b0);
   endtask

   task automatic add_blanks(input int count);
      for (int i = 0; i < count; i++)
         add_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB, 1'b0);
   endtask

   task automatic add_number();
      int          pick;
      logic [63:0] wide;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         add_text($sformatf("%0d", $urandom_range(0, 200)));
      end else if (pick < 65) begin
         wide = {32'($urandom), 32'($urandom)};
         add_text($sformatf("%0d", wide));
      end else if (pick < 80) begin
         case ($urandom_range(0, 5))
            0: add_text("18446744073709551615");
            1: add_text("18446744073709551616");
            2: add_text("18446744073709551614");
            3: add_text("1844674407370955161");
            4: add_text("18446744073709551619");
            default: add_text("999999999999999999999999");
         endcase
      end else if (pick < 90) begin
         add_text($sformatf("000%0d", $urandom_range(0, 99)));
      end else begin
         add_text($sformatf("%0d", $urandom_range(0, 9)));
      end
   endtask

   task automatic add_stray_byte();
      logic [7:0] value;
      value = 8'($urandom_range(0, 255));
      if (value == CHAR_LF)
         value = CHAR_CR;
      add_byte(value, 1'b0);
   endtask

   task automatic add_line();
      int kind;
      int tokens;
      int sign_pick;
      int ending;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         add_byte(CHAR_PERCENT, 1'b0);
         repeat ($urandom_range(0, 8)) add_stray_byte();
      end else if (kind < 14) begin
      end else if (kind < 22) begin
         repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         if ($urandom_range(0, 3) == 0)
            add_blanks($urandom_range(1, 3));
         tokens = $urandom_range(0, 6);
         for (int t = 0; t < tokens; t++) begin
            sign_pick = $urandom_range(0, 99);
            if (sign_pick < 10)
               add_byte(CHAR_PLUS, 1'b0);
            else if (sign_pick < 20)
               add_byte(CHAR_MINUS, 1'b0);
            if (sign_pick >= 95)
               add_stray_byte();
            else
               add_number();
            if ($urandom_range(0, 99) < 6)
               add_stray_byte();
            else if (t != tokens - 1 || $urandom_range(0, 1))
               add_blanks($urandom_range(1, 3));
         end
         if ($urandom_range(0, 9) == 0)
            add_byte(CHAR_CR, 1'b0);
      end
      ending = $urandom_range(0, 99);
      if (ending < 3)
         add_byte(CHAR_LF, 1'b1);
      else if (ending < 6 && pending_requests.size() != 0)
         pending_requests[$].end_of_text = 1'b1;
      else
         add_byte(CHAR_LF, 1'b0);
   endtask

   task automatic add_random_text(input int byte_count);
      int target_size;
      target_size = pending_requests.size() + byte_count;
      while (pending_requests.size() < target_size)
         add_line();
   endtask

   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_valid || expected_edges.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : drive_requests
      text_request_type next_request;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_text_byte(req_text_byte, req_end_of_text);
            bytes_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               next_request = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_text_byte <= next_request.text_byte;
               req_end_of_text <= next_request.end_of_text;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // edge monitor
   always @(posedge clock) begin : check_edges
      parsed_edge_type expected;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_edges.size() == 0) begin
               $error("unexpected edge: source %0d, target %0d",
                      rsp_edge_source, rsp_edge_target);
               fail_count++;
            end else begin
               expected = expected_edges.pop_front();
               edges_checked++;
               if (rsp_edge_source !== expected.source) begin
                  $error("edge_source mismatch: expected %0d, actual %0d",
                         expected.source, rsp_edge_source);
                  fail_count++;
               end
               if (rsp_edge_target !== expected.target) begin
                  $error("edge_target mismatch: expected %0d, actual %0d",
                         expected.target, rsp_edge_target);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or edge accepted for %0d cycles", idle_cycles);
         $display("adjacency_text_edge_parser_core_test NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 25;
      rsp_stall_pct = 72;
      add_text("%7\n");
      add_text(" +9 -1");
      add_byte(CHAR_CR, 1'b0);
      add_byte(CHAR_LF, 1'b0);
      add_text("\n");
      add_text("x5\t-\n");
      add_text("4");
      add_byte(8'h37, 1'b1);
      add_byte(8'hff, 1'b0);
      add_byte(8'h00, 1'b1);
      add_byte(CHAR_LF, 1'b1);
      add_random_text(PHASE_BYTES);
      wait_for_drain();

      req_idle_pct = 72;
      rsp_stall_pct = 25;
      add_random_text(PHASE_BYTES);
      wait_for_drain();

      req_idle_pct = 0;
      rsp_stall_pct = 0;
      add_random_text(PHASE_BYTES);
      wait_for_drain();
      repeat (10) @(posedge clock);

      $display("Parsed %0d text bytes across %0d lines under three stall patterns;",
               bytes_accepted, line_index);
      $display("%0d edges checked, %0d mismatches.", edges_checked, fail_count);
      if (fail_count == 0)
         $display("adjacency_text_edge_parser_core_test OK");
      else
         $display("adjacency_text_edge_parser_core_test NOT OK");
      $finish;
   end

endmodule
